>>> rtl/core/pckn_pkg.sv
// ----------------------------------------------------------------------------
// pckn_pkg
// Shared types and constants of the per-cell nearest-k insertion block.
// ----------------------------------------------------------------------------
package pckn_pkg;

   localparam int SLOTS_DEF      = 4;
   localparam int CELLS_DEF      = 65536;
   localparam int RANGE_BITS_DEF = 16;
   localparam int ID_BITS_DEF    = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_DATA_BITS  = 13;
   localparam int ZY_BITS        = 19;
   localparam int IDX_BITS       = 32;

   typedef enum logic [2:0] {
      CSR_FULL_X        = 3'd0,
      CSR_FULL_Y        = 3'd1,
      CSR_FULL_Z        = 3'd2,
      CSR_WIN_START_X   = 3'd3,
      CSR_WIN_START_Y   = 3'd4,
      CSR_WIN_WIDTH     = 3'd5,
      CSR_WIN_HEIGHT    = 3'd6,
      CSR_SOURCE_NUMBER = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_FAULT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL_ZY,
      F_MUL_X,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_CALC,
      B_FAULT
   } back_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] range_in;
      logic [15:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic [15:0] range_out;
      logic [7:0]  source_out;
      logic        inserted;
      logic        fault;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/core/pckn_front.sv
// ----------------------------------------------------------------------------
// pckn_front
// Accepts requests, holds the configuration, walks the scan window, computes
// the cell address and classifies each non-restart request into a queue operation.
// ----------------------------------------------------------------------------
module pckn_front #(
   parameter int CELLS      = pckn_pkg::CELLS_DEF,
   parameter int RANGE_BITS = pckn_pkg::RANGE_BITS_DEF,
   parameter int ID_BITS    = pckn_pkg::ID_BITS_DEF,
   localparam int AW        = $clog2(CELLS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 hold,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pckn_pkg::req_type                    req_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  pckn_pkg::csr_index_type              csr_index,
   input  logic [pckn_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic                                 q_push,
   input  logic                                 q_full,
   output pckn_pkg::op_type                     q_op,
   output logic [AW-1:0]                        q_addr,
   output logic [RANGE_BITS-1:0]                q_value,
   output logic [ID_BITS-1:0]                   q_id
);
   import pckn_pkg::*;

   localparam logic [IDX_BITS:0] CELLS_W = (IDX_BITS + 1)'(CELLS);

   logic [12:0] full_x_ff, full_y_ff, win_width_ff, win_height_ff;
   logic [6:0]  full_z_ff;
   logic [11:0] win_start_x_ff, win_start_y_ff;
   logic [7:0]  source_number_ff;

   front_state_type state_ff, state_in;
   logic [11:0] scan_x_ff, scan_x_in, scan_y_ff, scan_y_in;
   logic [5:0]  scan_z_ff, scan_z_in;
   logic        scan_done_ff, scan_done_in;
   logic [12:0] x_ff, x_in, y_ff, y_in;
   logic [5:0]  z_ff, z_in;
   logic [ZY_BITS-1:0]  zy_ff, zy_in, zy_prod;
   logic [IDX_BITS-1:0] idx_w;
   op_type              op_ff, op_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [RANGE_BITS-1:0] value_ff, value_in;
   logic [ID_BITS-1:0]  id_ff, id_in;

   assign zy_prod   = ZY_BITS'(z_ff) * ZY_BITS'(full_y_ff);
   assign idx_w     = IDX_BITS'(zy_ff) * IDX_BITS'(full_x_ff) + IDX_BITS'(x_ff);
   assign req_ready = (state_ff == F_IDLE) && !hold;
   assign csr_ready = 1'b1;
   assign q_op      = op_ff;
   assign q_addr    = addr_ff;
   assign q_value   = value_ff;
   assign q_id      = id_ff;

   always_comb begin
      state_in     = state_ff;
      scan_x_in    = scan_x_ff;
      scan_y_in    = scan_y_ff;
      scan_z_in    = scan_z_ff;
      scan_done_in = scan_done_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      zy_in        = zy_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      id_in        = id_ff;
      q_push       = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               value_in = RANGE_BITS'(req_data.range_in);
               id_in    = ID_BITS'(source_number_ff);
               addr_in  = AW'(req_data.cell_index);
               case (req_data.command)
                  CMD_INSERT: begin
                     if (scan_done_ff) begin
                        op_in    = OP_FAULT;
                        state_in = F_PUSH;
                     end else begin
                        x_in     = 13'(win_start_x_ff) + 13'(scan_x_ff);
                        y_in     = 13'(win_start_y_ff) + 13'(scan_y_ff);
                        z_in     = scan_z_ff;
                        state_in = F_MUL_ZY;
                        // advance x, then y, then z
                        if ((13'(scan_x_ff) + 13'd1 >= win_width_ff) || (&scan_x_ff)) begin
                           scan_x_in = '0;
                           if ((13'(scan_y_ff) + 13'd1 >= win_height_ff) || (&scan_y_ff)) begin
                              scan_y_in = '0;
                              if ((7'(scan_z_ff) + 7'd1 >= full_z_ff) || (&scan_z_ff)) begin
                                 scan_z_in    = '0;
                                 scan_done_in = 1'b1;
                              end else begin
                                 scan_z_in = scan_z_ff + 6'd1;
                              end
                           end else begin
                              scan_y_in = scan_y_ff + 12'd1;
                           end
                        end else begin
                           scan_x_in = scan_x_ff + 12'd1;
                        end
                     end
                  end
                  CMD_READ: begin
                     op_in    = ((IDX_BITS + 1)'(req_data.cell_index) >= CELLS_W) ?
                                OP_FAULT : OP_READ;
                     state_in = F_PUSH;
                  end
                  CMD_RESTART: begin
                     scan_x_in    = '0;
                     scan_y_in    = '0;
                     scan_z_in    = '0;
                     scan_done_in = 1'b0;
                  end
                  default: begin
                     op_in    = OP_FAULT;
                     state_in = F_PUSH;
                  end
               endcase
            end
         end
         F_MUL_ZY: begin
            zy_in    = zy_prod + ZY_BITS'(y_ff);
            state_in = F_MUL_X;
         end
         F_MUL_X: begin
            addr_in  = AW'(idx_w);
            state_in = F_PUSH;
            if ((x_ff >= full_x_ff) || (y_ff >= full_y_ff) || ({1'b0, z_ff} >= full_z_ff) ||
                ({1'b0, idx_w} >= CELLS_W)) begin
               op_in = OP_FAULT;
            end else begin
               op_in = OP_INSERT;
            end
         end
         F_PUSH: begin
            q_push = !q_full;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= F_IDLE;
         scan_x_ff        <= '0;
         scan_y_ff        <= '0;
         scan_z_ff        <= '0;
         scan_done_ff     <= 1'b0;
         full_x_ff        <= 13'd256;
         full_y_ff        <= 13'd256;
         full_z_ff        <= 7'd1;
         win_start_x_ff   <= '0;
         win_start_y_ff   <= '0;
         win_width_ff     <= 13'd1;
         win_height_ff    <= 13'd1;
         source_number_ff <= 8'd1;
      end else begin
         state_ff     <= state_in;
         scan_x_ff    <= scan_x_in;
         scan_y_ff    <= scan_y_in;
         scan_z_ff    <= scan_z_in;
         scan_done_ff <= scan_done_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FULL_X:        full_x_ff        <= csr_data;
               CSR_FULL_Y:        full_y_ff        <= csr_data;
               CSR_FULL_Z:        full_z_ff        <= csr_data[6:0];
               CSR_WIN_START_X:   win_start_x_ff   <= csr_data[11:0];
               CSR_WIN_START_Y:   win_start_y_ff   <= csr_data[11:0];
               CSR_WIN_WIDTH:     win_width_ff     <= csr_data;
               CSR_WIN_HEIGHT:    win_height_ff    <= csr_data;
               CSR_SOURCE_NUMBER: source_number_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zy_ff    <= zy_in;
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
      id_ff    <= id_in;
   end

endmodule

>>> rtl/core/pckn_fifo.sv
// ----------------------------------------------------------------------------
// pckn_fifo
// Short queue of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module pckn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pckn_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> rtl/core/pckn_back.sv
// ----------------------------------------------------------------------------
// pckn_back
// Holds the per-cell slot store, clears it after reset, and carries out queued
// operations: sorted insertion by read-modify-write, slot readout and fault responses.
// ----------------------------------------------------------------------------
module pckn_back #(
   parameter int SLOTS      = pckn_pkg::SLOTS_DEF,
   parameter int CELLS      = pckn_pkg::CELLS_DEF,
   parameter int RANGE_BITS = pckn_pkg::RANGE_BITS_DEF,
   parameter int ID_BITS    = pckn_pkg::ID_BITS_DEF,
   localparam int AW        = $clog2(CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  clear_busy,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  pckn_pkg::op_type      q_op,
   input  logic [AW-1:0]         q_addr,
   input  logic [RANGE_BITS-1:0] q_value,
   input  logic [ID_BITS-1:0]    q_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pckn_pkg::rsp_type     rsp_data
);
   import pckn_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [SLOTS-1:0][RANGE_BITS-1:0] rng;
      logic [SLOTS-1:0][ID_BITS-1:0]    id;
   } entry_type;

   entry_type mem_ram [CELLS];

   back_state_type        state_ff, state_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;
   op_type                op_ff, op_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [RANGE_BITS-1:0] value_ff, value_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [SW-1:0]         slot_ff, slot_in;
   entry_type             rd_ff, new_entry, wd;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  out_free, we, stored;
   logic [AW-1:0]         wa;
   logic [PW-1:0]         pos_c;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign clear_busy = (state_ff == B_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign stored     = (pos_c != PW'(SLOTS));

   // insertion point after equal ranges, larger entries move down one slot
   always_comb begin
      pos_c = PW'(SLOTS);
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (value_ff < rd_ff.rng[s]) begin
            pos_c = PW'(s);
         end
      end
      for (int s = 0; s < SLOTS; s++) begin
         if (PW'(s) < pos_c) begin
            new_entry.rng[s] = rd_ff.rng[s];
            new_entry.id[s]  = rd_ff.id[s];
         end else if (PW'(s) == pos_c) begin
            new_entry.rng[s] = value_ff;
            new_entry.id[s]  = id_ff;
         end else begin
            new_entry.rng[s] = rd_ff.rng[(s == 0) ? 0 : s - 1];
            new_entry.id[s]  = rd_ff.id[(s == 0) ? 0 : s - 1];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      wa           = addr_ff;
      wd           = new_entry;
      q_pop        = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            we         = 1'b1;
            wa         = clr_cnt_ff;
            wd.rng     = '1;
            wd.id      = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(CELLS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               op_in    = q_op;
               addr_in  = q_addr;
               value_in = q_value;
               id_in    = q_id;
               slot_in  = '0;
               state_in = (q_op == OP_FAULT) ? B_FAULT : B_READ;
            end
         end
         B_READ: begin
            state_in = B_CALC;
         end
         B_FAULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.fault = 1'b1;
               rsp_in.last  = 1'b1;
               state_in     = B_IDLE;
            end
         end
         B_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (op_ff == OP_READ) begin
                  rsp_in.slot       = 3'(slot_ff);
                  rsp_in.range_out  = 16'(rd_ff.rng[slot_ff]);
                  rsp_in.source_out = 8'(rd_ff.id[slot_ff]);
                  rsp_in.last       = (slot_ff == SW'(SLOTS - 1));
                  if (slot_ff == SW'(SLOTS - 1)) begin
                     state_in = B_IDLE;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end else begin
                  rsp_in.last = 1'b1;
                  if (stored) begin
                     we                = 1'b1;
                     rsp_in.slot       = 3'(pos_c);
                     rsp_in.range_out  = 16'(value_ff);
                     rsp_in.source_out = 8'(id_ff);
                     rsp_in.inserted   = 1'b1;
                  end else begin
                     rsp_in.slot       = 3'(SLOTS - 1);
                     rsp_in.range_out  = 16'(rd_ff.rng[SLOTS-1]);
                     rsp_in.source_out = 8'(rd_ff.id[SLOTS-1]);
                  end
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
      id_ff    <= id_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ram[wa] <= wd;
      end
      if (state_ff == B_READ) begin
         rd_ff <= mem_ram[addr_ff];
      end
   end

endmodule

>>> rtl/core/per_cell_k_nearest_insert.sv
// ----------------------------------------------------------------------------
// per_cell_k_nearest_insert
// Per-cell store of the SLOTS smallest ranges with sorted insertion, a
// self-walking scan window, slot readout and scan restart.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data   (pckn_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data   (pckn_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// An insert passes in the front through two address multiply stages and the queue
// push, and in the back through the queue pop, the registered store read and the
// read-modify-write into the response register. A fault skips the store read and
// responds sooner. The front takes a new request only after it has pushed the last
// one into the queue. A read gives SLOTS responses, back to back while rsp_ready is
// high. After reset the store is cleared one cell a cycle with req_ready low; csr
// writes are taken throughout. A stalled rsp fills the queue and then holds
// req_ready low.
// ----------------------------------------------------------------------------
module per_cell_k_nearest_insert #(
   parameter int SLOTS      = pckn_pkg::SLOTS_DEF,
   parameter int CELLS      = pckn_pkg::CELLS_DEF,
   parameter int RANGE_BITS = pckn_pkg::RANGE_BITS_DEF,
   parameter int ID_BITS    = pckn_pkg::ID_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pckn_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pckn_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  pckn_pkg::csr_index_type            csr_index,
   input  logic [pckn_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import pckn_pkg::*;

   localparam int AW = $clog2(CELLS);
   localparam int QW = $bits(op_type) + AW + RANGE_BITS + ID_BITS;

   logic                  clear_busy;
   logic                  q_push, q_full, q_pop, q_empty;
   op_type                f_op;
   logic [AW-1:0]         f_addr;
   logic [RANGE_BITS-1:0] f_value;
   logic [ID_BITS-1:0]    f_id;
   logic [QW-1:0]         q_din, q_dout;

   pckn_front #(
      .CELLS      (CELLS),
      .RANGE_BITS (RANGE_BITS),
      .ID_BITS    (ID_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clear_busy),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_op      (f_op),
      .q_addr    (f_addr),
      .q_value   (f_value),
      .q_id      (f_id)
   );

   assign q_din = {f_op, f_addr, f_value, f_id};

   pckn_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   pckn_back #(
      .SLOTS      (SLOTS),
      .CELLS      (CELLS),
      .RANGE_BITS (RANGE_BITS),
      .ID_BITS    (ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_op       (op_type'(q_dout[QW-1 -: $bits(op_type)])),
      .q_addr     (q_dout[RANGE_BITS+ID_BITS +: AW]),
      .q_value    (q_dout[ID_BITS +: RANGE_BITS]),
      .q_id       (q_dout[ID_BITS-1:0]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/core/pckn_checker.sv
// ----------------------------------------------------------------------------
// pckn_checker
// Port-level checks of the per-cell nearest-k insertion block.
// ----------------------------------------------------------------------------
module pckn_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pckn_pkg::rsp_type rsp_data
);
   import pckn_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_fault_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> rsp_data.last && !rsp_data.inserted)
      else $error("fault response not single");

   // advance read slots back to back
   a_read_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid && (rsp_data.slot == $past(rsp_data.slot) + 3'd1))
      else $error("read slots out of sequence");

endmodule

bind per_cell_k_nearest_insert pckn_checker u_pckn_checker (.*);
